// File: rtl/button_debounce_long_press_defines.svh
// Assertion macros shared by the debounce block.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BDLP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BDLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bdlp_pkg.sv
// Package: field widths, register map and shared types of the debounce block.
`default_nettype none
package bdlp_pkg;

	localparam int FIELD_W = 3;
	localparam int CNT_W   = 16;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;
	localparam int IDX_W   = 2;

	localparam logic [CNT_W-1:0] LONG_RESET   = 16'd300;
	localparam logic [CNT_W-1:0] REPEAT_RESET = 16'd100;

	localparam logic [IDX_W-1:0] REG_LONG   = 2'd0;
	localparam logic [IDX_W-1:0] REG_REPEAT = 2'd1;
	localparam logic [IDX_W-1:0] REG_LEVEL  = 2'd2;

	typedef logic [FIELD_W-1:0] field_t;

	typedef struct packed {
		logic [CNT_W-1:0] long_press_ticks;
		logic [CNT_W-1:0] repeat_ticks;
		logic             pressed_level;
	} cfg_t;

	// Sample history of one button as seen after the shift.
	typedef struct packed {
		logic oldest;
		logic middle;
		logic newest;
		logic stable;
	} hist_t;

	// Per-button update result.
	typedef struct packed {
		logic stable;
		logic press_set;
		logic long_set;
	} lane_t;

endpackage
`default_nettype wire

// File: rtl/bdlp_in_if.sv
// Input channel: raw levels and acknowledge masks for one tick.
`default_nettype none
interface bdlp_in_if;
	logic             valid;
	logic             ready;
	bdlp_pkg::field_t raw_levels;
	bdlp_pkg::field_t press_ack_mask;
	bdlp_pkg::field_t long_ack_mask;

	modport source (output valid, raw_levels, press_ack_mask, long_ack_mask, input ready);
	modport sink   (input valid, raw_levels, press_ack_mask, long_ack_mask, output ready);
endinterface
`default_nettype wire

// File: rtl/bdlp_out_if.sv
// Output channel: flags and debounced levels after one tick.
`default_nettype none
interface bdlp_out_if;
	logic             valid;
	logic             ready;
	bdlp_pkg::field_t press_flags;
	bdlp_pkg::field_t long_flags;
	bdlp_pkg::field_t debounced_levels;

	modport source (output valid, press_flags, long_flags, debounced_levels, input ready);
	modport sink   (input valid, press_flags, long_flags, debounced_levels, output ready);
endinterface
`default_nettype wire

// File: rtl/bdlp_lane.sv
// One button: agreement check, debounced level update and hold counter.
`default_nettype none
module bdlp_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  bdlp_pkg::cfg_t              cfg,
	input  bdlp_pkg::hist_t             hist,
	output bdlp_pkg::lane_t             upd
);

	logic [bdlp_pkg::CNT_W-1:0] cnt_q;
	logic [bdlp_pkg::CNT_W-1:0] cnt_dec;
	logic [bdlp_pkg::CNT_W-1:0] cnt_nxt;
	logic                       agree;
	logic                       is_pressed;

	assign agree      = (hist.oldest == hist.middle) && (hist.middle == hist.newest);
	assign is_pressed = (hist.newest == cfg.pressed_level);
	assign cnt_dec    = cnt_q - bdlp_pkg::CNT_W'(1);

	// Decide level change, press event, countdown and repeat event
	always_comb begin
		upd.stable    = hist.stable;
		upd.press_set = 1'b0;
		upd.long_set  = 1'b0;
		cnt_nxt       = cnt_q;
		if (agree) begin
			if (hist.stable != hist.newest) begin
				upd.stable = hist.newest;
				if (is_pressed) begin
					upd.press_set = 1'b1;
					cnt_nxt       = cfg.long_press_ticks;
				end
			end else if (cnt_dec == '0) begin
				upd.long_set = is_pressed;
				cnt_nxt      = cfg.repeat_ticks;
			end else begin
				cnt_nxt = cnt_dec;
			end
		end
	end

	// Hold counter advances once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= bdlp_pkg::LONG_RESET;
		end else if (en) begin
			cnt_q <= cnt_nxt;
		end
	end

endmodule
`default_nettype wire

// File: rtl/button_debounce_long_press.sv
// Top level: three-sample button debouncer with press and long-press repeat flags.
// Path: an accepted beat is held in the input register, then its result is registered in the state registers.
// Throughput: one beat per cycle while the result is not stalled; input register then one pass of per-button logic.
// Results leave from the state registers, so a stalled result holds the pipe.
// Reset: async low; levels released, flags clear, counters 300, registers at defaults.
`default_nettype none
`include "button_debounce_long_press_defines.svh"
module button_debounce_long_press #(
	parameter int BUTTON_COUNT = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bdlp_pkg::ADDR_W-1:0]   paddr,
	input  logic [bdlp_pkg::DATA_W-1:0]   pwdata,
	output logic [bdlp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	bdlp_in_if.sink                       item,
	bdlp_out_if.source                    result
);

	bdlp_pkg::cfg_t              cfg_q;
	logic [bdlp_pkg::IDX_W-1:0]  reg_idx;
	logic                        cfg_wr;

	logic                        valid_s1;
	bdlp_pkg::field_t            raw_s1;
	bdlp_pkg::field_t            pack_s1;
	bdlp_pkg::field_t            lack_s1;

	logic                        out_valid_q;
	logic                        adv;
	logic                        fire;

	logic [BUTTON_COUNT-1:0]     raw_w;
	logic [BUTTON_COUNT-1:0]     pack_w;
	logic [BUTTON_COUNT-1:0]     lack_w;
	logic [BUTTON_COUNT-1:0]     middle_q;
	logic [BUTTON_COUNT-1:0]     newest_q;
	logic [BUTTON_COUNT-1:0]     stable_q;
	logic [BUTTON_COUNT-1:0]     press_q;
	logic [BUTTON_COUNT-1:0]     long_q;
	logic [BUTTON_COUNT-1:0]     stable_nxt;
	logic [BUTTON_COUNT-1:0]     press_set;
	logic [BUTTON_COUNT-1:0]     long_set;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[bdlp_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= bdlp_pkg::LONG_RESET;
			cfg_q.repeat_ticks     <= bdlp_pkg::REPEAT_RESET;
			cfg_q.pressed_level    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bdlp_pkg::REG_LONG:   cfg_q.long_press_ticks <= pwdata[bdlp_pkg::CNT_W-1:0];
				bdlp_pkg::REG_REPEAT: cfg_q.repeat_ticks     <= pwdata[bdlp_pkg::CNT_W-1:0];
				bdlp_pkg::REG_LEVEL:  cfg_q.pressed_level    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bdlp_pkg::REG_LONG:
				prdata = bdlp_pkg::DATA_W'(cfg_q.long_press_ticks);
			bdlp_pkg::REG_REPEAT:
				prdata = bdlp_pkg::DATA_W'(cfg_q.repeat_ticks);
			bdlp_pkg::REG_LEVEL:
				prdata = bdlp_pkg::DATA_W'(cfg_q.pressed_level);
			default:
				prdata = '0;
		endcase
	end

	// Handshake: stage 1 advances when the result slot is empty or being taken
	assign adv        = !out_valid_q || result.ready;
	assign fire       = valid_s1 && adv;
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			raw_s1  <= item.raw_levels;
			pack_s1 <= item.press_ack_mask;
			lack_s1 <= item.long_ack_mask;
		end
	end

	// Per-button lanes; buttons beyond the field width see level 0 and no ack
	for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_btn
		bdlp_pkg::hist_t hist;
		bdlp_pkg::lane_t upd;

		if (g < bdlp_pkg::FIELD_W) begin : g_fld
			assign raw_w[g]  = raw_s1[g];
			assign pack_w[g] = pack_s1[g];
			assign lack_w[g] = lack_s1[g];
		end else begin : g_pad
			assign raw_w[g]  = 1'b0;
			assign pack_w[g] = 1'b0;
			assign lack_w[g] = 1'b0;
		end

		assign hist.oldest = middle_q[g];
		assign hist.middle = newest_q[g];
		assign hist.newest = raw_w[g];
		assign hist.stable = stable_q[g];

		bdlp_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (fire),
			.cfg    (cfg_q),
			.hist   (hist),
			.upd    (upd)
		);

		assign stable_nxt[g] = upd.stable;
		assign press_set[g]  = upd.press_set;
		assign long_set[g]   = upd.long_set;
	end

	// Shift history, update levels, clear acked flags then set new events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			middle_q <= '1;
			newest_q <= '1;
			stable_q <= '1;
			press_q  <= '0;
			long_q   <= '0;
		end else if (fire) begin
			middle_q <= newest_q;
			newest_q <= raw_w;
			stable_q <= stable_nxt;
			press_q  <= (press_q & ~pack_w) | press_set;
			long_q   <= (long_q & ~lack_w) | long_set;
		end
	end

	// Result beat straight from the state registers
	assign result.valid = out_valid_q;
	for (genvar k = 0; k < bdlp_pkg::FIELD_W; k++) begin : g_out
		if (k < BUTTON_COUNT) begin : g_live
			assign result.press_flags[k]      = press_q[k];
			assign result.long_flags[k]       = long_q[k];
			assign result.debounced_levels[k] = stable_q[k];
		end else begin : g_zero
			assign result.press_flags[k]      = 1'b0;
			assign result.long_flags[k]       = 1'b0;
			assign result.debounced_levels[k] = 1'b0;
		end
	end

	// Checks
	`BDLP_ASSERT_NOW(a_no_overrun, valid_s1 && !adv, !item.ready, "beat taken while stage 1 blocked")
	`BDLP_ASSERT_NEXT(a_no_loss, fire, out_valid_q, "processed beat did not reach result")
	`BDLP_ASSERT_NOW(a_no_phantom, $rose(out_valid_q), $past(valid_s1), "result without a beat")

endmodule
`default_nettype wire
